// ===== sv/switch_ack_holdback_congestion_ctrl_top_macros.svh =====
// Assertion macros shared by the RTL.
// ASSERT_IMPLIES: consequent holds in the same cycle as the antecedent.
// ASSERT_NEXT: consequent holds in the cycle after the antecedent.
`ifndef SWITCH_ACK_HOLDBACK_CONGESTION_CTRL_TOP_MACROS_SVH
`define SWITCH_ACK_HOLDBACK_CONGESTION_CTRL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sahcc_pkg.sv =====
`timescale 1ns / 1ps
package sahcc_pkg;

   localparam int ThresholdWidth = 24;
   localparam int WindowWidth    = 16;
   localparam int ReleaseWidth   = 16;
   localparam int ActionWidth    = 3;
   localparam int PhaseWidth     = 2;
   localparam int CsrIndexWidth  = 1;
   localparam int DivSteps       = ThresholdWidth;
   localparam int DivCountWidth  = $clog2(DivSteps);

   localparam int AckStoreDepthDefault = 1024;

   localparam logic [ThresholdWidth-1:0] ThresholdReset = 24'd60000;
   localparam logic [ThresholdWidth-1:0] MinWindow      = 24'd1446;
   localparam logic [ThresholdWidth-1:0] MaxWindow      = 24'd65535;
   localparam logic [ThresholdWidth-1:0] ExcessFloor    = 24'd6000;

   // result actions
   localparam logic [ActionWidth-1:0] ACT_FWD     = 3'd0;
   localparam logic [ActionWidth-1:0] ACT_HELD    = 3'd1;
   localparam logic [ActionWidth-1:0] ACT_CORRUPT = 3'd2;
   localparam logic [ActionWidth-1:0] ACT_FULL    = 3'd3;
   localparam logic [ActionWidth-1:0] ACT_DONE    = 3'd4;

   // congestion phases
   localparam logic [PhaseWidth-1:0] PH_UNCONG = 2'd0;
   localparam logic [PhaseWidth-1:0] PH_CONG   = 2'd1;
   localparam logic [PhaseWidth-1:0] PH_LEAVE  = 2'd2;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_ENABLE    = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_THRESHOLD = 1'd1;

   typedef struct packed {
      logic load_req;
      logic decide;
      logic div_start;
      logic div_sel;      // 0: divide by held count, 1: by window
      logic take_window;
      logic take_batch;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic release_needed;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== sv/sahcc_ifs.sv =====
`timescale 1ns / 1ps
interface sahcc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic [sahcc_pkg::ThresholdWidth-1:0] send_queue_bytes;
   logic                                is_ack;
   logic                                is_corrupt;

   modport source (output valid, cmd, send_queue_bytes, is_ack, is_corrupt, input ready);
   modport sink   (input valid, cmd, send_queue_bytes, is_ack, is_corrupt, output ready);
endinterface

interface sahcc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sahcc_pkg::ActionWidth-1:0]  action;
   logic [sahcc_pkg::ReleaseWidth-1:0] released_acks;
   logic [sahcc_pkg::WindowWidth-1:0]  assigned_window;
   logic [sahcc_pkg::PhaseWidth-1:0]   cong_state;

   modport source (output valid, action, released_acks, assigned_window, cong_state,
                   input ready);
   modport sink   (input valid, action, released_acks, assigned_window, cong_state,
                   output ready);
endinterface

// ===== sv/sahcc_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module sahcc_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [sahcc_pkg::ThresholdWidth-1:0] dividend,
   input  logic [sahcc_pkg::WindowWidth-1:0]    divisor,
   output logic                                 done,
   output logic [sahcc_pkg::ThresholdWidth-1:0] quotient
);

   localparam int QW = sahcc_pkg::ThresholdWidth;
   localparam int DW = sahcc_pkg::WindowWidth;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [sahcc_pkg::DivCountWidth-1:0] count_ff, count_in;
   logic [DW-1:0]                       rem_ff, rem_in;
   logic [QW-1:0]                       quot_ff, quot_in;
   logic [DW-1:0]                       divisor_ff, divisor_in;
   logic [DW:0]                         rem_shift;
   logic [DW:0]                         diff;

   always_comb begin
      rem_shift  = {rem_ff, quot_ff[QW-1]};
      diff       = rem_shift - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = sahcc_pkg::DivCountWidth'(sahcc_pkg::DivSteps - 1);
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, divisor_ff}) begin
            rem_in  = diff[DW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[DW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/sahcc_datapath.sv =====
`timescale 1ns / 1ps
// Congestion state, request capture, batch arithmetic and response register.
module sahcc_datapath #(
   parameter int ACK_STORE_DEPTH = sahcc_pkg::AckStoreDepthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [sahcc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [sahcc_pkg::ThresholdWidth-1:0] csr_write_data,
   input  logic                                 req_valid,
   input  logic                                 req_cmd,
   input  logic [sahcc_pkg::ThresholdWidth-1:0] req_send_queue_bytes,
   input  logic                                 req_is_ack,
   input  logic                                 req_is_corrupt,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [sahcc_pkg::ActionWidth-1:0]    rsp_action,
   output logic [sahcc_pkg::ReleaseWidth-1:0]   rsp_released_acks,
   output logic [sahcc_pkg::WindowWidth-1:0]    rsp_assigned_window,
   output logic [sahcc_pkg::PhaseWidth-1:0]     rsp_cong_state,
   input  sahcc_pkg::dp_cmd_type                cmd,
   output sahcc_pkg::dp_status_type             status
);

   localparam int HeldWidth = $clog2(ACK_STORE_DEPTH + 1);
   localparam int TW        = sahcc_pkg::ThresholdWidth;

   logic                                enable_ff;
   logic [TW-1:0]                       threshold_ff;
   logic [sahcc_pkg::PhaseWidth-1:0]    phase_ff, phase_in;
   logic [TW-1:0]                       peak_ff, peak_in;
   logic [HeldWidth-1:0]                held_ff, held_in;
   logic                                cmd_ff;
   logic [TW-1:0]                       queue_ff;
   logic                                ack_ff;
   logic                                corrupt_ff;
   logic [sahcc_pkg::ActionWidth-1:0]   action_ff, action_in;
   logic [sahcc_pkg::WindowWidth-1:0]   window_ff, window_in;
   logic [sahcc_pkg::ReleaseWidth-1:0]  batch_ff;
   logic                                rsp_valid_ff;
   logic [sahcc_pkg::ActionWidth-1:0]   rsp_action_ff;
   logic [sahcc_pkg::ReleaseWidth-1:0]  rsp_released_ff;
   logic [sahcc_pkg::WindowWidth-1:0]   rsp_window_ff;
   logic [sahcc_pkg::PhaseWidth-1:0]    rsp_phase_ff;

   logic                                release_req;
   logic                                held_full;
   logic [TW-1:0]                       excess;
   logic [TW-1:0]                       half;
   logic [TW-1:0]                       quotient;
   logic                                div_done;
   logic [sahcc_pkg::WindowWidth-1:0]   divisor;
   logic [TW-1:0]                       batch_size;
   logic [HeldWidth-1:0]                batch_held;

   assign held_full = (held_ff == HeldWidth'(ACK_STORE_DEPTH));
   assign excess    = queue_ff - threshold_ff;
   assign half      = peak_ff >> 1;

   // event decision on the captured request
   always_comb begin
      phase_in    = phase_ff;
      peak_in     = peak_ff;
      action_in   = sahcc_pkg::ACT_FWD;
      release_req = 1'b0;
      held_in     = held_ff;
      if (!cmd_ff) begin
         if (corrupt_ff) begin
            action_in = sahcc_pkg::ACT_CORRUPT;
         end else if (enable_ff) begin
            if (queue_ff >= threshold_ff) begin
               phase_in = sahcc_pkg::PH_CONG;
               if (excess > peak_ff) peak_in = excess;
               if (peak_in > threshold_ff) peak_in = threshold_ff;
               if (ack_ff) begin
                  if (held_full) begin
                     action_in = sahcc_pkg::ACT_FULL;
                  end else begin
                     action_in = sahcc_pkg::ACT_HELD;
                     held_in   = held_ff + 1'b1;
                  end
               end
            end else if (phase_ff == sahcc_pkg::PH_LEAVE) begin
               if (ack_ff) begin
                  if (held_full) begin
                     action_in = sahcc_pkg::ACT_FULL;
                  end else begin
                     action_in = sahcc_pkg::ACT_HELD;
                     held_in   = held_ff + 1'b1;
                  end
               end
            end else if (queue_ff <= peak_ff && phase_ff == sahcc_pkg::PH_CONG) begin
               phase_in    = sahcc_pkg::PH_LEAVE;
               release_req = 1'b1;
            end else if (queue_ff == '0) begin
               phase_in    = sahcc_pkg::PH_UNCONG;
               peak_in     = '0;
               release_req = 1'b1;
            end
         end
      end else begin
         action_in = sahcc_pkg::ACT_DONE;
         if (enable_ff) begin
            if (queue_ff <= peak_ff && phase_ff == sahcc_pkg::PH_CONG) begin
               phase_in    = sahcc_pkg::PH_LEAVE;
               release_req = 1'b1;
            end else if (queue_ff == '0) begin
               phase_in    = sahcc_pkg::PH_UNCONG;
               peak_in     = '0;
               release_req = 1'b1;
            end else if (queue_ff <= half && phase_ff == sahcc_pkg::PH_LEAVE) begin
               peak_in     = (half <= sahcc_pkg::ExcessFloor) ? '0 : half;
               release_req = 1'b1;
            end
         end
      end
   end

   // window = clamp(K / held), batch = min(held, K / window + 1)
   always_comb begin
      if (quotient < sahcc_pkg::MinWindow) begin
         window_in = sahcc_pkg::WindowWidth'(sahcc_pkg::MinWindow);
      end else if (quotient > sahcc_pkg::MaxWindow) begin
         window_in = sahcc_pkg::WindowWidth'(sahcc_pkg::MaxWindow);
      end else begin
         window_in = quotient[sahcc_pkg::WindowWidth-1:0];
      end
      batch_size = quotient + 1'b1;
      batch_held = (batch_size > TW'(held_ff)) ? held_ff : batch_size[HeldWidth-1:0];
   end

   assign divisor = cmd.div_sel ? window_ff : sahcc_pkg::WindowWidth'(held_ff);

   sahcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (threshold_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         threshold_ff <= sahcc_pkg::ThresholdReset;
         phase_ff     <= sahcc_pkg::PH_UNCONG;
         peak_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               sahcc_pkg::CSR_ENABLE:    enable_ff    <= csr_write_data[0];
               sahcc_pkg::CSR_THRESHOLD: threshold_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.decide) begin
            phase_ff <= phase_in;
            peak_ff  <= peak_in;
            held_ff  <= held_in;
         end else if (cmd.take_batch) begin
            held_ff <= held_ff - batch_held;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_req) begin
         cmd_ff     <= req_cmd;
         queue_ff   <= req_send_queue_bytes;
         ack_ff     <= req_is_ack;
         corrupt_ff <= req_is_corrupt;
      end
      if (cmd.decide) begin
         action_ff <= action_in;
         window_ff <= '0;
         batch_ff  <= '0;
      end
      if (cmd.take_window) window_ff <= window_in;
      if (cmd.take_batch)  batch_ff  <= sahcc_pkg::ReleaseWidth'(batch_held);
      if (cmd.load_rsp) begin
         rsp_action_ff   <= action_ff;
         rsp_released_ff <= batch_ff;
         rsp_window_ff   <= window_ff;
         rsp_phase_ff    <= phase_ff;
      end
   end

   assign status.req_valid      = req_valid;
   assign status.release_needed = release_req && (held_ff != '0);
   assign status.div_done       = div_done;
   assign status.rsp_free       = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_action          = rsp_action_ff;
   assign rsp_released_acks   = rsp_released_ff;
   assign rsp_assigned_window = rsp_window_ff;
   assign rsp_cong_state      = rsp_phase_ff;

endmodule

// ===== sv/sahcc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: capture, decide, optional two divisions, hand over the response.
module sahcc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  sahcc_pkg::dp_status_type status,
   output sahcc_pkg::dp_cmd_type    cmd,
   output logic                     req_ready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV_WIN,
      ST_START_BATCH,
      ST_DIV_BATCH,
      ST_OUTPUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.release_needed) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_WIN;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_DIV_WIN: begin
            if (status.div_done) begin
               cmd.take_window = 1'b1;
               state_in        = ST_START_BATCH;
            end
         end
         ST_START_BATCH: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = ST_DIV_BATCH;
         end
         ST_DIV_BATCH: begin
            if (status.div_done) begin
               cmd.take_batch = 1'b1;
               state_in       = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== sv/switch_ack_holdback_congestion_ctrl_top.sv =====
// channel   direction  handshake      payload
// req_bus   in         valid/ready    cmd, send_queue_bytes, is_ack, is_corrupt
// rsp_bus   out        valid/ready    action, released_acks, assigned_window, cong_state
// csr_*     in         write enable   csr_index, csr_write_data
//
// A request without a release goes from the decide state straight to the output state,
// and the input reopens once the output state has loaded the response register.
// A request that releases held ACKs first runs two 24-step divisions (K / held, then
// K / window) one after the other through the one divider before its response is loaded.
// One request is in flight at a time; the next is taken once the response is registered.
// A stalled response holds in its register and the sequencer waits for it to drain.
// Reset is synchronous: disabled control, K = 60000, uncongested, nothing held.
`timescale 1ns / 1ps
`include "switch_ack_holdback_congestion_ctrl_top_macros.svh"
module switch_ack_holdback_congestion_ctrl_top #(
   parameter int ACK_STORE_DEPTH = sahcc_pkg::AckStoreDepthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [sahcc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [sahcc_pkg::ThresholdWidth-1:0] csr_write_data,
   sahcc_req_if.sink                            req_bus,
   sahcc_rsp_if.source                          rsp_bus
);

   sahcc_pkg::dp_cmd_type    dp_cmd;
   sahcc_pkg::dp_status_type dp_status;
   logic                     ctrl_ready;
   logic                     rsp_with_release;
   logic                     rsp_without_release;
   logic                     window_at_floor;
   logic                     window_zero;

   // sequencer: one request at a time
   sahcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (dp_status),
      .cmd       (dp_cmd),
      .req_ready (ctrl_ready)
   );

   assign req_bus.ready = ctrl_ready;

   // state, arithmetic and response register
   sahcc_datapath #(
      .ACK_STORE_DEPTH (ACK_STORE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_bus.valid),
      .req_cmd              (req_bus.cmd),
      .req_send_queue_bytes (req_bus.send_queue_bytes),
      .req_is_ack           (req_bus.is_ack),
      .req_is_corrupt       (req_bus.is_corrupt),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_action           (rsp_bus.action),
      .rsp_released_acks    (rsp_bus.released_acks),
      .rsp_assigned_window  (rsp_bus.assigned_window),
      .rsp_cong_state       (rsp_bus.cong_state),
      .cmd                  (dp_cmd),
      .status               (dp_status)
   );

   assign rsp_with_release    = rsp_bus.valid && (rsp_bus.released_acks != '0);
   assign rsp_without_release = rsp_bus.valid && (rsp_bus.released_acks == '0);
   assign window_at_floor     = rsp_bus.assigned_window >=
                                sahcc_pkg::WindowWidth'(sahcc_pkg::MinWindow);
   assign window_zero         = (rsp_bus.assigned_window == '0);

   // a taken request closes the input until its response is registered
   `ASSERT_NEXT(a_single_request, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   // a released batch always carries at least the minimum window
   `ASSERT_IMPLIES(a_window_floor, clock, reset, rsp_with_release, window_at_floor)
   // no release means no window
   `ASSERT_IMPLIES(a_no_release_no_window, clock, reset, rsp_without_release, window_zero)
   // a division just started never reports done in the following cycle
   `ASSERT_NEXT(a_div_start_done, clock, reset, dp_cmd.div_start, !dp_status.div_done)

endmodule
